// File: rtl/cnrf_pkg.sv
`timescale 1ns / 1ps

package cnrf_pkg;

	localparam int unsigned WordW   = 16;
	localparam int unsigned ColorW  = 8;
	localparam int unsigned ModeW   = 2;
	localparam int unsigned BitCntW = 5;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [WordW-1:0]   STRIDE     = 16'd320;
	localparam logic [ColorW-1:0]  FILL_COLOR = 8'hEF;
	localparam logic [BitCntW-1:0] WORD_BITS  = 5'd16;

	// Register reset values
	localparam logic [WordW-1:0] CLIP_LEFT_RST  = 16'd0;
	localparam logic [WordW-1:0] CLIP_RIGHT_RST = 16'd320;
	localparam logic [WordW-1:0] BAND_TOP_RST   = 16'd0;
	localparam logic [WordW-1:0] BUF_OFS_RST    = 16'd0;

	// Register indexes
	localparam logic [CfgIdxW-1:0] REG_CLIP_LEFT  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_CLIP_RIGHT = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_BAND_TOP   = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_BUF_OFS    = 2'd3;

	// Request kinds
	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// Fill modes
	localparam logic [ModeW-1:0] MODE_SPARSE_EF = 2'd1;
	localparam logic [ModeW-1:0] MODE_SPARSE_00 = 2'd2;

	// Clipped rectangle handed from the clip unit to the fill sequencer
	typedef struct packed {
		logic             nonempty;
		logic [WordW-1:0] pointer;
		logic [WordW-1:0] line_skip;
		logic [WordW-1:0] width;
		logic [WordW-1:0] height;
	} clip_t;

	function automatic logic not_positive(input logic [WordW-1:0] v);
		return (v == '0) || v[WordW-1];
	endfunction

endpackage

// File: rtl/clipped_noise_rect_fill.sv
`timescale 1ns / 1ps

// Channel  Direction  tdata (low bit up)                        tuser         tlast
// s_*      in         fill_mode, rect_x, rect_y, rect_width,    opcode        -
//                     rect_height, seed, 6 zero bits
// m_*      out        pixel_address, pixel_color                write_enable  last
// cfg_*    in         cfg_data = 16-bit register value, cfg_index selects it
//
// Each request is held in the input register and its pixel, if any, is loaded
// into the output register on the way out; one request per cycle is taken
// while the output is not stalled. The fill state (noise word, pointer and
// counters) is updated in that single step, so a step follows a step directly.
// A stalled output holds the input register; the input side keeps accepting
// while the output register is empty or being drained.
// arst_n clears the pipeline, the fill state and the registers to their defaults.

module clipped_noise_rect_fill import cnrf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [WordW-1:0]   cfg_data,
	// request stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [87:0]        s_tdata,   // fill_mode, rect_x, rect_y, rect_width,
	                                      // rect_height, seed, zero pad
	input  logic               s_tuser,   // opcode
	// pixel stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [23:0]        m_tdata,   // pixel_address, pixel_color
	output logic               m_tuser,   // write_enable
	output logic               m_tlast
);

	// configuration registers
	logic [WordW-1:0] clip_left_q, clip_right_q, band_top_q, buf_ofs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q  <= CLIP_LEFT_RST;
			clip_right_q <= CLIP_RIGHT_RST;
			band_top_q   <= BAND_TOP_RST;
			buf_ofs_q    <= BUF_OFS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CLIP_LEFT:  clip_left_q  <= cfg_data;
				REG_CLIP_RIGHT: clip_right_q <= cfg_data;
				REG_BAND_TOP:   band_top_q   <= cfg_data;
				REG_BUF_OFS:    buf_ofs_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	logic             v_s1, op_s1;
	logic [ModeW-1:0] mode_s1;
	logic [WordW-1:0] x_s1, y_s1, w_s1, h_s1, seed_s1;
	logic             advance;

	assign advance  = v_s1 && (!m_tvalid || m_tready);
	assign s_tready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			mode_s1 <= s_tdata[1:0];
			x_s1    <= s_tdata[17:2];
			y_s1    <= s_tdata[33:18];
			w_s1    <= s_tdata[49:34];
			h_s1    <= s_tdata[65:50];
			seed_s1 <= s_tdata[81:66];
		end
	end

	// clip the rectangle of a start request
	clip_t rect;

	cnrf_clip u_clip (
		.rect_x        (x_s1),
		.rect_y        (y_s1),
		.rect_width    (w_s1),
		.rect_height   (h_s1),
		.clip_left     (clip_left_q),
		.clip_right    (clip_right_q),
		.band_top      (band_top_q),
		.buffer_offset (buf_ofs_q),
		.rect          (rect)
	);

	// fill state
	logic               busy_q, carry_q;
	logic [WordW-1:0]   noise_q, ptr_q, cols_q, rows_q, span_q, skip_q;
	logic [BitCntW-1:0] bits_q;
	logic [ModeW-1:0]   mode_q;
	logic [ColorW-1:0]  tcolor_q;

	// next-state of one pixel step
	logic               sparse, bit_out, we_n, last_n, carry_n, busy_n;
	logic [WordW-1:0]   noise_n, ptr_n, cols_n, rows_n, old;
	logic [WordW:0]     ptr_sum;
	logic [BitCntW-1:0] bits_n;
	logic [ColorW-1:0]  tcolor_n, color_n;

	always_comb begin
		sparse   = (mode_q == MODE_SPARSE_EF) || (mode_q == MODE_SPARSE_00);
		bit_out  = noise_q[WordW-1];
		noise_n  = {noise_q[WordW-2:0], carry_q};
		carry_n  = bit_out;
		tcolor_n = tcolor_q;
		if (sparse) begin
			color_n = (mode_q == MODE_SPARSE_EF) ? FILL_COLOR : '0;
			we_n    = bit_out;
		end else begin
			if (bit_out) tcolor_n = tcolor_q ^ FILL_COLOR;
			color_n = tcolor_n;
			we_n    = 1'b1;
		end
		ptr_n = ptr_q + 16'd1;

		// reseed after every 16 pixels
		bits_n = bits_q - 5'd1;
		old    = noise_n;
		if (bits_n == '0) begin
			if (sparse) noise_n = old ^ {old[11:0], carry_n, old[15:13]};
			else        noise_n = old ^ {old[12:0], carry_n, old[15:14]};
			carry_n = 1'b0;
			bits_n  = WORD_BITS;
		end

		// row end: carry takes the pointer overflow
		cols_n  = cols_q - 16'd1;
		rows_n  = rows_q;
		busy_n  = busy_q;
		last_n  = 1'b0;
		ptr_sum = {1'b0, ptr_n} + {1'b0, skip_q};
		if (cols_n == '0) begin
			carry_n = ptr_sum[WordW];
			ptr_n   = ptr_sum[WordW-1:0];
			rows_n  = rows_q - 16'd1;
			if (rows_n == '0) begin
				last_n = 1'b1;
				busy_n = 1'b0;
			end else begin
				cols_n = span_q;
			end
		end
	end

	logic do_start, do_step;
	assign do_start = advance && (op_s1 == OP_START);
	assign do_step  = advance && (op_s1 == OP_STEP) && busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			noise_q  <= '0;
			carry_q  <= 1'b0;
			bits_q   <= WORD_BITS;
			ptr_q    <= '0;
			cols_q   <= '0;
			rows_q   <= '0;
			span_q   <= '0;
			skip_q   <= '0;
			mode_q   <= '0;
			tcolor_q <= '0;
		end else if (do_start) begin
			// an empty rectangle only drops the running fill
			busy_q <= rect.nonempty;
			if (rect.nonempty) begin
				noise_q  <= seed_s1;
				carry_q  <= 1'b1;
				bits_q   <= WORD_BITS;
				ptr_q    <= rect.pointer;
				cols_q   <= rect.width;
				rows_q   <= rect.height;
				span_q   <= rect.width;
				skip_q   <= rect.line_skip;
				mode_q   <= mode_s1;
				tcolor_q <= '0;
			end
		end else if (do_step) begin
			busy_q   <= busy_n;
			noise_q  <= noise_n;
			carry_q  <= carry_n;
			bits_q   <= bits_n;
			ptr_q    <= ptr_n;
			cols_q   <= cols_n;
			rows_q   <= rows_n;
			tcolor_q <= tcolor_n;
		end
	end

	// output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_step) begin
			m_tdata <= {color_n, ptr_q};
			m_tuser <= we_n;
			m_tlast <= last_n;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

// File: rtl/cnrf_clip.sv
`timescale 1ns / 1ps

module cnrf_clip import cnrf_pkg::*; (
	input  logic [WordW-1:0] rect_x,
	input  logic [WordW-1:0] rect_y,
	input  logic [WordW-1:0] rect_width,
	input  logic [WordW-1:0] rect_height,
	input  logic [WordW-1:0] clip_left,
	input  logic [WordW-1:0] clip_right,
	input  logic [WordW-1:0] band_top,
	input  logic [WordW-1:0] buffer_offset,
	output clip_t            rect
);

	logic [WordW-1:0] x, y, w, h, d, row_off;
	logic             ok;

	always_comb begin
		x  = rect_x;
		y  = rect_y;
		w  = rect_width;
		h  = rect_height;
		ok = !not_positive(w) && !not_positive(h);

		// left edge
		d = x - clip_left;
		if (d[WordW-1]) begin
			w = w + d;
			if (not_positive(w)) ok = 1'b0;
			x = clip_left;
		end
		// right edge
		d = (x + w) - clip_right;
		if (!d[WordW-1]) begin
			w = w - d;
			if (not_positive(w)) ok = 1'b0;
		end
		// top of band
		d = y - band_top;
		if (d[WordW-1]) begin
			h = h + d;
			if (not_positive(h)) ok = 1'b0;
			y = band_top;
		end
		// bottom, against the right limit
		d = (y + h) - clip_right;
		if (!d[WordW-1]) begin
			h = h - d;
			if (not_positive(h)) ok = 1'b0;
		end

		// byte swap plus y<<6: y*320 for small y
		row_off = {y[7:0], y[15:8]} + {y[WordW-7:0], 6'b0};

		rect.nonempty  = ok;
		rect.pointer   = buffer_offset + row_off + x;
		rect.line_skip = STRIDE - w;
		rect.width     = w;
		rect.height    = h;
	end

endmodule

// File: rtl/cnrf_checker.sv
`timescale 1ns / 1ps

module cnrf_checker import cnrf_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic               s_tuser,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [23:0]        m_tdata,
	input logic               m_tuser,
	input logic               m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("pixel changed while stalled");

	a_color: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[23:16] == FILL_COLOR) || (m_tdata[23:16] == 8'h00))
		else $error("pixel color outside the noise palette");

	// an empty output register never blocks the request side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("request refused while the pixel register is empty");

	// a pixel that appears on an idle output comes from a step request taken in through the input register
	a_pixel_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == OP_STEP), 2))
		else $error("pixel without a step request");

endmodule

bind clipped_noise_rect_fill cnrf_checker u_cnrf_checker (.*);
